// File: design/cli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_pkg: shared types and constants of the core-local interruptor
// Bus word layouts, operation codes, controller states and the command
// bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package cli_pkg;

  // Widths fixed by the word layout
  localparam int KIND_W   = 2;
  localparam int OFFSET_W = 15;
  localparam int DATA_W   = 64;
  localparam int IRQ_W    = 8;
  localparam int HARTS_W  = 4;

  // Largest hart count the 4-bit register can select
  localparam int HARTS_LIMIT = (1 << HARTS_W) - 1;

  localparam int DEFAULT_MAX_HARTS = 8;
  localparam logic [HARTS_W-1:0] HARTS_RESET = 4'd8;

  // Address map
  localparam logic [OFFSET_W-1:0] SOFT_REGION_SIZE  = 15'h4000;
  localparam logic [OFFSET_W-1:0] TIME_COUNT_OFFSET = 15'h7FF8;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic {
    REGION_SOFT  = 1'b0,
    REGION_TIMER = 1'b1
  } region_t;

  typedef struct packed {
    kind_t               kind;
    region_t             region;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  software_irq;
    logic [IRQ_W-1:0]  timer_irq;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_REPORT = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the incoming word
    logic exec;       // apply the access or tick to the state
    logic report;     // evaluate interrupt lines and issue the result
    logic cfg_write;  // update the hart count register
  } cmd_t;

endpackage

// File: design/cli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_ctrl: sequencing controller
// Three-state machine: idle/accept, execute the access, report the result.
// Also gates the configuration channel so it is only taken while idle.
// ----------------------------------------------------------------------------
module cli_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cfg_valid,
  output logic          busy,
  output logic          cfg_ready,
  output cli_pkg::cmd_t cmd
);
  import cli_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    busy          = 1'b1;
    cfg_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequence checks
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_EXEC))
    else $error("accepted word did not enter execute");

  a_exec_report: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> cmd.report)
    else $error("execute not followed by report");

  a_report_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.report |=> !busy)
    else $error("controller not idle after report");

endmodule

// File: design/cli_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_datapath: interruptor register file and timer
// Holds the software pending bits, per-hart compares, the shared counter and
// the hart count; decodes one access, updates state, then forms the result.
// ----------------------------------------------------------------------------
module cli_datapath #(
  parameter int MAX_HARTS = cli_pkg::DEFAULT_MAX_HARTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cli_pkg::cmd_t                cmd,
  input  cli_pkg::item_t               item,
  input  logic [cli_pkg::HARTS_W-1:0]  cfg_data,
  output logic                         done,
  output cli_pkg::result_t             result
);
  import cli_pkg::*;

  // Only slots the hart count register can reach need storage
  localparam int SLOTS = (MAX_HARTS < HARTS_LIMIT) ? MAX_HARTS : HARTS_LIMIT;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [HARTS_W-1:0] SLOTS_N = HARTS_W'(SLOTS);

  item_t               item_q;
  logic [HARTS_W-1:0]  harts;
  logic                sw_pend [SLOTS];
  logic [DATA_W-1:0]   compare [SLOTS];
  logic [DATA_W-1:0]   count;
  logic [DATA_W-1:0]   rdata;
  logic [DATA_W-1:0]   rdata_next;

  logic [HARTS_W-1:0]  n_eff;
  logic [IRQ_W-1:0]    present_mask;
  logic [12:0]         soft_hart;
  logic [11:0]         tmr_hart;
  logic [IDX_W-1:0]    soft_idx;
  logic [IDX_W-1:0]    tmr_idx;
  logic                soft_hit;
  logic                tmr_hit;
  logic                cnt_hit;
  logic [IRQ_W-1:0]    sw_bits;
  logic [IRQ_W-1:0]    tm_bits;

  // Effective hart count and the mask of visible interrupt lines
  assign n_eff = (harts > SLOTS_N) ? SLOTS_N : harts;

  always_comb begin
    for (int i = 0; i < IRQ_W; i++) begin
      present_mask[i] = (HARTS_W'(i) < n_eff);
    end
  end

  // Address decode
  assign soft_hart = item_q.offset[OFFSET_W-1:2];
  assign tmr_hart  = item_q.offset[OFFSET_W-1:3];
  assign soft_idx  = soft_hart[IDX_W-1:0];
  assign tmr_idx   = tmr_hart[IDX_W-1:0];
  assign soft_hit  = (item_q.region == REGION_SOFT) &&
                     (item_q.offset < SOFT_REGION_SIZE) &&
                     (soft_hart < 13'(n_eff));
  assign tmr_hit   = (item_q.region == REGION_TIMER) && (tmr_hart < 12'(n_eff));
  assign cnt_hit   = (item_q.region == REGION_TIMER) && !tmr_hit &&
                     (item_q.offset == TIME_COUNT_OFFSET);

  // Read mux
  always_comb begin
    rdata_next = '0;
    if (item_q.kind == KIND_READ) begin
      if (soft_hit) begin
        rdata_next = {{(DATA_W-1){1'b0}}, sw_pend[soft_idx]};
      end else if (tmr_hit) begin
        rdata_next = compare[tmr_idx];
      end else if (cnt_hit) begin
        rdata_next = count;
      end
    end
  end

  // Word capture and read data
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.exec) begin
      rdata <= rdata_next;
    end
  end

  // Hart count register
  always_ff @(posedge clk) begin
    if (rst) begin
      harts <= HARTS_RESET;
    end else if (cmd.cfg_write) begin
      harts <= cfg_data;
    end
  end

  // Pending bits, compares and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        sw_pend[i] <= 1'b0;
        compare[i] <= '1;
      end
      count <= '0;
    end else if (cmd.exec) begin
      if (item_q.kind == KIND_TICK) begin
        count <= count + 1'b1;
      end else if (item_q.kind == KIND_WRITE) begin
        if (soft_hit) begin
          sw_pend[soft_idx] <= item_q.write_data[0];
        end else if (tmr_hit) begin
          compare[tmr_idx] <= item_q.write_data;
        end else if (cnt_hit) begin
          count <= item_q.write_data;
        end
      end
    end
  end

  // Per-hart interrupt lines
  for (genvar g = 0; g < IRQ_W; g++) begin : g_irq
    if (g < SLOTS) begin : g_on
      assign sw_bits[g] = sw_pend[g] & present_mask[g];
      assign tm_bits[g] = (count >= compare[g]) & present_mask[g];
    end else begin : g_off
      assign sw_bits[g] = 1'b0;
      assign tm_bits[g] = 1'b0;
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      result.read_data    <= rdata;
      result.software_irq <= sw_bits;
      result.timer_irq    <= tm_bits;
    end
  end

  // Checks
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done))
    else $error("result strobe longer than one cycle");

  a_absent_quiet: assert property (@(posedge clk) disable iff (rst)
    done |-> (((result.software_irq | result.timer_irq) & ~present_mask) == '0))
    else $error("interrupt shown for an absent hart");

  a_tick_adds: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && item_q.kind == KIND_TICK) |=> (count == $past(count) + 1'b1))
    else $error("tick did not advance the counter");

endmodule

// File: design/core_local_interruptor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_local_interruptor_top: core-local interruptor
// Software interrupt bits, per-hart timer compares and the shared time
// counter behind a start/busy command port with a one-cycle result strobe.
// ----------------------------------------------------------------------------
// For each word (read, write or tick), start is taken while busy is low, the
// access is applied in the next cycle, interrupt lines are evaluated in the
// one after, and the result is shown with done high for exactly one cycle,
// during which busy is already low again. busy stays high in the execute
// and report states, so a new word is not taken until the last one has
// been reported. done cannot be held off: the receiver must take the
// result in that cycle. cfg_ready is high only while idle.
// ----------------------------------------------------------------------------
module core_local_interruptor_top #(
  parameter int MAX_HARTS = cli_pkg::DEFAULT_MAX_HARTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  cli_pkg::item_t               item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cli_pkg::HARTS_W-1:0]  cfg_data,
  output logic                         done,
  output cli_pkg::result_t             result
);
  import cli_pkg::*;

  cmd_t cmd;

  // Sequencer
  cli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Register file, timer and result
  cli_datapath #(
    .MAX_HARTS (MAX_HARTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

endmodule
